### design/gbr_pkg.sv
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared widths, register indexes and control structs of the gesture block
// ----------------------------------------------------------------------------
`default_nettype none

package gbr_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int DELAY_W     = 24;
    localparam int STEP_W      = 16;
    localparam int REQ_W       = 2;
    localparam int BUTTON_W    = 8;
    localparam int GESTURE_W   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PRESS   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_DELAY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_DELAY  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_STEP   = 2'd2;

    // largest gesture code
    localparam logic [GESTURE_W-1:0] GESTURE_MAX = 4'd10;

    localparam logic [DELAY_W-1:0] SHORT_DELAY_RESET = 24'd500000;
    localparam logic [DELAY_W-1:0] LONG_DELAY_RESET  = 24'd9500000;
    localparam logic [STEP_W-1:0]  TICK_STEP_RESET   = 16'd100;

    typedef struct packed {
        logic [DELAY_W-1:0] short_delay;
        logic [DELAY_W-1:0] long_delay;
        logic [STEP_W-1:0]  tick_step;
    } cfg_t;

    typedef struct packed {
        logic                 valid;
        logic [GESTURE_W-1:0] gesture;
    } result_t;

endpackage

`default_nettype wire

### design/gbr_req_if.sv
// ----------------------------------------------------------------------------
// gbr_req_if
// Request channel: press, release and tick words with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface gbr_req_if;
    logic                         valid;
    logic                         ready;
    logic [gbr_pkg::REQ_W-1:0]    req_type;
    logic [gbr_pkg::BUTTON_W-1:0] button;

    modport source (output valid, output req_type, output button, input ready);
    modport sink   (input valid, input req_type, input button, output ready);
endinterface

`default_nettype wire

### design/gbr_gest_if.sv
// ----------------------------------------------------------------------------
// gbr_gest_if
// Result channel: gesture words with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface gbr_gest_if;
    logic                          valid;
    logic                          ready;
    logic [gbr_pkg::GESTURE_W-1:0] gesture;

    modport source (output valid, output gesture, input ready);
    modport sink   (input valid, input gesture, output ready);
endinterface

`default_nettype wire

### design/gbr_cfg_regs.sv
// ----------------------------------------------------------------------------
// gbr_cfg_regs
// Write-only configuration registers: short delay, long delay, tick step
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [gbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [gbr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output gbr_pkg::cfg_t                        cfg
);
    import gbr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHORT_DELAY: cfg_next.short_delay = cfg_data[DELAY_W-1:0];
                REG_LONG_DELAY:  cfg_next.long_delay  = cfg_data[DELAY_W-1:0];
                REG_TICK_STEP:   cfg_next.tick_step   = cfg_data[STEP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_delay <= SHORT_DELAY_RESET;
            cfg_reg.long_delay  <= LONG_DELAY_RESET;
            cfg_reg.tick_step   <= TICK_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/gbr_fsm.sv
// ----------------------------------------------------------------------------
// gbr_fsm
// Input register, gesture state machine with transition table and countdown
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_fsm (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gbr_pkg::cfg_t     cfg,
    input  wire logic              out_free,
    output gbr_pkg::result_t       res,
    gbr_req_if.sink                request
);
    import gbr_pkg::*;

    typedef enum logic [3:0] {
        ST_INV    = 4'd0,
        ST_IDLE   = 4'd1,
        ST_B0     = 4'd2,
        ST_B1     = 4'd3,
        ST_B0S    = 4'd4,
        ST_B1S    = 4'd5,
        ST_BOTH   = 4'd6,
        ST_BOTHS  = 4'd7,
        ST_B0OFF  = 4'd8,
        ST_B1OFF  = 4'd9,
        ST_B0OFF1 = 4'd10,
        ST_B1OFF0 = 4'd11
    } state_t;

    typedef logic [2:0] event_t;

    localparam event_t EV_P0    = 3'd0;
    localparam event_t EV_R0    = 3'd1;
    localparam event_t EV_P1    = 3'd2;
    localparam event_t EV_R1    = 3'd3;
    localparam event_t EV_SHORT = 3'd4;
    localparam event_t EV_LONG  = 3'd5;

    localparam logic [GESTURE_W-1:0] G_TAP0      = 4'd0;
    localparam logic [GESTURE_W-1:0] G_TAP1      = 4'd1;
    localparam logic [GESTURE_W-1:0] G_TAPBOTH   = 4'd2;
    localparam logic [GESTURE_W-1:0] G_PRESS0    = 4'd3;
    localparam logic [GESTURE_W-1:0] G_PRESS1    = 4'd4;
    localparam logic [GESTURE_W-1:0] G_PRESSBOTH = 4'd5;
    localparam logic [GESTURE_W-1:0] G_LONG0     = 4'd6;
    localparam logic [GESTURE_W-1:0] G_LONG1     = 4'd7;
    localparam logic [GESTURE_W-1:0] G_LONGBOTH  = 4'd8;
    localparam logic [GESTURE_W-1:0] G_SLIDE01   = 4'd9;
    localparam logic [GESTURE_W-1:0] G_SLIDE10   = 4'd10;

    localparam int CMP_W = (COUNT_WIDTH > DELAY_W) ? COUNT_WIDTH : DELAY_W;

    typedef struct packed {
        logic       trig;
        logic [3:0] code;
    } entry_t;

    function automatic entry_t go(state_t s);
        entry_t e;
        e.trig = 1'b0;
        e.code = s;
        return e;
    endfunction

    function automatic entry_t fire(logic [GESTURE_W-1:0] g);
        entry_t e;
        e.trig = 1'b1;
        e.code = g;
        return e;
    endfunction

    function automatic entry_t next_entry(state_t s, event_t ev);
        entry_t e;
        e = go(ST_IDLE);
        unique case (s)
            ST_IDLE:
                case (ev)
                    EV_P0:   e = go(ST_B0);
                    EV_P1:   e = go(ST_B1);
                    default: e = go(ST_IDLE);
                endcase
            ST_B0:
                case (ev)
                    EV_P0:    e = go(ST_B0);
                    EV_R0:    e = go(ST_B0OFF);
                    EV_P1:    e = go(ST_BOTH);
                    EV_R1:    e = go(ST_B0);
                    EV_SHORT: e = go(ST_B0S);
                    default:  e = go(ST_INV);
                endcase
            ST_B1:
                case (ev)
                    EV_P0:    e = go(ST_BOTH);
                    EV_R0:    e = go(ST_B1);
                    EV_P1:    e = go(ST_B1);
                    EV_R1:    e = go(ST_B1OFF);
                    EV_SHORT: e = go(ST_B1S);
                    default:  e = go(ST_INV);
                endcase
            ST_B0S:
                case (ev)
                    EV_P0:    e = go(ST_B0S);
                    EV_R0:    e = fire(G_PRESS0);
                    EV_P1:    e = go(ST_BOTH);
                    EV_R1:    e = go(ST_B0S);
                    EV_SHORT: e = go(ST_INV);
                    default:  e = fire(G_LONG0);
                endcase
            ST_B1S:
                case (ev)
                    EV_P0:    e = go(ST_BOTH);
                    EV_R0:    e = go(ST_B1S);
                    EV_P1:    e = go(ST_B1S);
                    EV_R1:    e = fire(G_PRESS1);
                    EV_SHORT: e = go(ST_INV);
                    default:  e = fire(G_LONG1);
                endcase
            ST_BOTH:
                case (ev)
                    EV_P0:    e = go(ST_BOTH);
                    EV_R0:    e = fire(G_TAPBOTH);
                    EV_P1:    e = go(ST_BOTH);
                    EV_R1:    e = fire(G_TAPBOTH);
                    EV_SHORT: e = go(ST_BOTHS);
                    default:  e = go(ST_INV);
                endcase
            ST_BOTHS:
                case (ev)
                    EV_P0:    e = go(ST_BOTHS);
                    EV_R0:    e = fire(G_PRESSBOTH);
                    EV_P1:    e = go(ST_BOTHS);
                    EV_R1:    e = fire(G_PRESSBOTH);
                    EV_SHORT: e = go(ST_INV);
                    default:  e = fire(G_LONGBOTH);
                endcase
            ST_B0OFF:
                case (ev)
                    EV_P0:    e = go(ST_B0);
                    EV_R0:    e = go(ST_B0OFF);
                    EV_P1:    e = go(ST_B0OFF1);
                    EV_R1:    e = go(ST_B0OFF);
                    EV_SHORT: e = fire(G_TAP0);
                    default:  e = go(ST_INV);
                endcase
            ST_B1OFF:
                case (ev)
                    EV_P0:    e = go(ST_B1);
                    EV_R0:    e = go(ST_B1OFF);
                    EV_P1:    e = go(ST_B1OFF0);
                    EV_R1:    e = go(ST_B1OFF);
                    EV_SHORT: e = fire(G_TAP1);
                    default:  e = go(ST_INV);
                endcase
            ST_B0OFF1:
                case (ev)
                    EV_R1:    e = fire(G_SLIDE01);
                    EV_SHORT: e = fire(G_SLIDE01);
                    EV_LONG:  e = go(ST_INV);
                    default:  e = go(ST_B0OFF1);
                endcase
            ST_B1OFF0:
                case (ev)
                    EV_R1:    e = fire(G_SLIDE10);
                    EV_SHORT: e = fire(G_SLIDE10);
                    EV_LONG:  e = go(ST_INV);
                    default:  e = go(ST_B1OFF0);
                endcase
            // invalid state: every event leads back to idle
            default: e = go(ST_IDLE);
        endcase
        return e;
    endfunction

    // delay saturated to what the counter can hold
    function automatic logic [COUNT_WIDTH-1:0] clamp_count(logic [DELAY_W-1:0] d);
        logic [CMP_W-1:0]       v;
        logic [COUNT_WIDTH-1:0] cmax;
        cmax = '1;
        v    = CMP_W'(d);
        if (v > CMP_W'(cmax))
            v = CMP_W'(cmax);
        return v[COUNT_WIDTH-1:0];
    endfunction

    logic                  item_valid_reg;
    logic [REQ_W-1:0]      req_type_reg;
    logic [BUTTON_W-1:0]   button_reg;
    state_t                state_reg;
    state_t                state_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                  armed_reg;
    logic                  armed_next;
    logic                  pend_long_reg;
    logic                  pend_long_next;
    logic                  advance;
    logic                  accept;

    assign advance       = item_valid_reg && out_free;
    assign request.ready = !item_valid_reg || out_free;
    assign accept        = request.valid && request.ready;

    always_comb
    begin
        logic                   do_ev;
        event_t                 ev;
        entry_t                 e;
        logic [COUNT_WIDTH-1:0] step_ext;

        state_next     = state_reg;
        count_next     = count_reg;
        armed_next     = armed_reg;
        pend_long_next = pend_long_reg;
        res.valid      = 1'b0;
        res.gesture    = '0;
        do_ev          = 1'b0;
        ev             = EV_P0;
        e              = go(ST_IDLE);
        step_ext       = COUNT_WIDTH'(cfg.tick_step);

        if (advance)
        begin
            case (req_type_reg) inside
                REQ_PRESS, REQ_RELEASE:
                begin
                    if (button_reg <= BUTTON_W'(1))
                    begin
                        do_ev = 1'b1;
                        ev    = {1'b0, button_reg[0], req_type_reg[0]};
                    end
                end
                REQ_TICK:
                begin
                    if (armed_reg)
                    begin
                        if (count_reg == '0)
                        begin
                            armed_next = 1'b0;
                            do_ev      = 1'b1;
                            ev         = pend_long_reg ? EV_LONG : EV_SHORT;
                        end
                        else if (count_reg > step_ext)
                            count_next = count_reg - step_ext;
                        else
                            count_next = '0;
                    end
                end
                default: ;
            endcase

            if (do_ev)
            begin
                e = next_entry(state_reg, ev);
                if (e.trig)
                begin
                    res.valid   = 1'b1;
                    res.gesture = e.code;
                    state_next  = ST_IDLE;
                    armed_next  = 1'b0;
                end
                else
                begin
                    state_next = state_t'(e.code);
                    // entering idle leaves the timer as it is
                    if (state_t'(e.code) != ST_IDLE)
                    begin
                        if (ev == EV_LONG)
                            armed_next = 1'b0;
                        else if (ev == EV_SHORT)
                        begin
                            count_next     = clamp_count(cfg.long_delay);
                            pend_long_next = 1'b1;
                            armed_next     = 1'b1;
                        end
                        else
                        begin
                            count_next     = clamp_count(cfg.short_delay);
                            pend_long_next = 1'b0;
                            armed_next     = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            armed_reg      <= 1'b0;
            pend_long_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;
            state_reg     <= state_next;
            count_reg     <= count_next;
            armed_reg     <= armed_next;
            pend_long_reg <= pend_long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= request.req_type;
            button_reg   <= request.button;
        end
    end

endmodule

`default_nettype wire

### design/gbr_out_stage.sv
// ----------------------------------------------------------------------------
// gbr_out_stage
// Result register holding one gesture word until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gbr_pkg::result_t res,
    output logic                  out_free,
    gbr_gest_if.source            result
);
    import gbr_pkg::*;

    logic                 valid_reg;
    logic [GESTURE_W-1:0] gesture_reg;

    assign out_free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (out_free)
            valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res.valid)
            gesture_reg <= res.gesture;
    end

    assign result.valid   = valid_reg;
    assign result.gesture = gesture_reg;

endmodule

`default_nettype wire

### design/two_button_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// two_button_gesture_recognizer
// Tap, press, long and slide gesture recognition on two touch buttons
// ----------------------------------------------------------------------------
// One request word (press, release or tick) is taken per cycle while ready
// is high. A word is held in an input register and resolved, once the result
// register is free, by one lookup in the 12x6 transition table plus one
// countdown update, and its gesture word passes through the result register.
// That register lets a new request enter while a gesture waits; ready drops
// only when both registers are full. The user writes configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
`default_nettype none

module two_button_gesture_recognizer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [gbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [gbr_pkg::CFG_DATA_W-1:0]  cfg_data,
    gbr_req_if.sink                              request,
    gbr_gest_if.source                           result
);
    import gbr_pkg::*;

    cfg_t    cfg;
    result_t res;
    logic    out_free;

    gbr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gbr_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .out_free (out_free),
        .res      (res),
        .request  (request)
    );

    gbr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .out_free (out_free),
        .result   (result)
    );

endmodule

`default_nettype wire

### design/gbr_checker.sv
// ----------------------------------------------------------------------------
// gbr_checker
// Port-level checks of the gesture block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [gbr_pkg::GESTURE_W-1:0] gesture
);
    import gbr_pkg::*;

    // a stalled gesture word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(gesture))
        else $error("gesture word changed while stalled");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> gesture <= GESTURE_MAX)
        else $error("gesture code out of range");

    // request side stalls only behind a stalled result
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> res_valid && !res_ready)
        else $error("request ready low without result backpressure");

    // a fresh gesture word follows a request that passed the input and result registers
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_valid && req_ready, 2))
        else $error("gesture word without a matching request");

endmodule

bind two_button_gesture_recognizer gbr_checker u_gbr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .gesture   (result.gesture)
);

`default_nettype wire

### tb/two_button_gesture_recognizer_test.sv
// ----------------------------------------------------------------------------
// two_button_gesture_recognizer_test
// Self-checking bench for the two-button gesture recognizer
// ----------------------------------------------------------------------------
// A queue of press, release and tick words feeds a clocked driver. A clocked
// monitor keeps its own copy of the gesture state machine and countdown timer,
// predicts the gesture word of every accepted request and checks the result
// channel in order. Both channels idle in random bursts. The delays and the
// tick step are rewritten between phases while the block is quiet.
// ----------------------------------------------------------------------------

module two_button_gesture_recognizer_test;

    import gbr_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [3:0] {
        ST_INVALID, ST_IDLE, ST_B0_ON, ST_B1_ON, ST_B0_SHORT, ST_B1_SHORT,
        ST_BOTH_ON, ST_BOTH_SHORT, ST_B0_OFF, ST_B1_OFF, ST_B0_OFF_B1_ON,
        ST_B1_OFF_B0_ON
    } gstate_t;

    typedef enum logic [2:0] {
        EV_PRESS0, EV_RELEASE0, EV_PRESS1, EV_RELEASE1, EV_SHORT_TO, EV_LONG_TO
    } button_event_t;

    typedef enum logic [GESTURE_W-1:0] {
        G_TAP0, G_TAP1, G_TAP_BOTH, G_PRESS0, G_PRESS1, G_PRESS_BOTH,
        G_LONG0, G_LONG1, G_LONG_BOTH, G_SLIDE01, G_SLIDE10
    } gesture_t;

    typedef struct packed {
        logic     emit;
        gesture_t gesture;
        gstate_t  nxt;
    } transition_t;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [BUTTON_W-1:0] button;
    } req_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    gbr_req_if  req_ch ();
    gbr_gest_if gest_ch ();

    two_button_gesture_recognizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req_ch),
        .result    (gest_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predicted block state and configuration
    logic [DELAY_W-1:0]     short_delay_r = SHORT_DELAY_RESET;
    logic [DELAY_W-1:0]     long_delay_r  = LONG_DELAY_RESET;
    logic [STEP_W-1:0]      tick_step_r   = TICK_STEP_RESET;
    gstate_t                gesture_state = ST_IDLE;
    logic [COUNT_WIDTH-1:0] countdown     = '0;
    logic                   timer_armed   = 1'b0;
    logic                   pending_long  = 1'b0;

    req_word_t              pending_words[$];
    logic [GESTURE_W-1:0]   gesture_expect[$];
    req_word_t              next_word;
    logic [GESTURE_W-1:0]   expected_gesture;
    logic                   req_taken = 1'b0;
    logic                   idle_enable = 1'b1;
    int                     src_gap = 0;
    int                     sink_gap = 0;
    int                     quiet_cycles = 0;
    int                     error_count = 0;
    int                     items_made = 0;

    function automatic transition_t goes(gstate_t s);
        transition_t t;
        t.emit = 1'b0;
        t.gesture = G_TAP0;
        t.nxt = s;
        return t;
    endfunction

    function automatic transition_t emits(gesture_t g);
        transition_t t;
        t.emit = 1'b1;
        t.gesture = g;
        t.nxt = ST_IDLE;
        return t;
    endfunction

    function automatic transition_t lookup_transition(gstate_t s, button_event_t e);
        transition_t t;
        t = goes(s);
        case (s)
            ST_IDLE:
                case (e)
                    EV_PRESS0: t = goes(ST_B0_ON);
                    EV_PRESS1: t = goes(ST_B1_ON);
                    default:   t = goes(ST_IDLE);
                endcase
            ST_B0_ON:
                case (e)
                    EV_RELEASE0: t = goes(ST_B0_OFF);
                    EV_PRESS1:   t = goes(ST_BOTH_ON);
                    EV_SHORT_TO: t = goes(ST_B0_SHORT);
                    EV_LONG_TO:  t = goes(ST_INVALID);
                    default:     t = goes(ST_B0_ON);
                endcase
            ST_B1_ON:
                case (e)
                    EV_PRESS0:   t = goes(ST_BOTH_ON);
                    EV_RELEASE1: t = goes(ST_B1_OFF);
                    EV_SHORT_TO: t = goes(ST_B1_SHORT);
                    EV_LONG_TO:  t = goes(ST_INVALID);
                    default:     t = goes(ST_B1_ON);
                endcase
            ST_B0_SHORT:
                case (e)
                    EV_RELEASE0: t = emits(G_PRESS0);
                    EV_PRESS1:   t = goes(ST_BOTH_ON);
                    EV_SHORT_TO: t = goes(ST_INVALID);
                    EV_LONG_TO:  t = emits(G_LONG0);
                    default:     t = goes(ST_B0_SHORT);
                endcase
            ST_B1_SHORT:
                case (e)
                    EV_PRESS0:   t = goes(ST_BOTH_ON);
                    EV_RELEASE1: t = emits(G_PRESS1);
                    EV_SHORT_TO: t = goes(ST_INVALID);
                    EV_LONG_TO:  t = emits(G_LONG1);
                    default:     t = goes(ST_B1_SHORT);
                endcase
            ST_BOTH_ON:
                case (e)
                    EV_RELEASE0, EV_RELEASE1: t = emits(G_TAP_BOTH);
                    EV_SHORT_TO: t = goes(ST_BOTH_SHORT);
                    EV_LONG_TO:  t = goes(ST_INVALID);
                    default:     t = goes(ST_BOTH_ON);
                endcase
            ST_BOTH_SHORT:
                case (e)
                    EV_RELEASE0, EV_RELEASE1: t = emits(G_PRESS_BOTH);
                    EV_SHORT_TO: t = goes(ST_INVALID);
                    EV_LONG_TO:  t = emits(G_LONG_BOTH);
                    default:     t = goes(ST_BOTH_SHORT);
                endcase
            ST_B0_OFF:
                case (e)
                    EV_PRESS0:   t = goes(ST_B0_ON);
                    EV_PRESS1:   t = goes(ST_B0_OFF_B1_ON);
                    EV_SHORT_TO: t = emits(G_TAP0);
                    EV_LONG_TO:  t = goes(ST_INVALID);
                    default:     t = goes(ST_B0_OFF);
                endcase
            ST_B1_OFF:
                case (e)
                    EV_PRESS0:   t = goes(ST_B1_ON);
                    EV_PRESS1:   t = goes(ST_B1_OFF_B0_ON);
                    EV_SHORT_TO: t = emits(G_TAP1);
                    EV_LONG_TO:  t = goes(ST_INVALID);
                    default:     t = goes(ST_B1_OFF);
                endcase
            ST_B0_OFF_B1_ON:
                case (e)
                    EV_RELEASE1, EV_SHORT_TO: t = emits(G_SLIDE01);
                    EV_LONG_TO:  t = goes(ST_INVALID);
                    default:     t = goes(ST_B0_OFF_B1_ON);
                endcase
            ST_B1_OFF_B0_ON:
                case (e)
                    EV_RELEASE1, EV_SHORT_TO: t = emits(G_SLIDE10);
                    EV_LONG_TO:  t = goes(ST_INVALID);
                    default:     t = goes(ST_B1_OFF_B0_ON);
                endcase
            default: t = goes(ST_IDLE);
        endcase
        return t;
    endfunction

    // delays beyond the counter range saturate
    function automatic logic [COUNT_WIDTH-1:0] load_count(logic [DELAY_W-1:0] d);
        longint unsigned cmax;
        cmax = (longint'(1) << COUNT_WIDTH) - 1;
        return (longint'(d) > cmax) ? cmax[COUNT_WIDTH-1:0] : COUNT_WIDTH'(d);
    endfunction

    task automatic apply_event(button_event_t e);
        transition_t t;
        t = lookup_transition(gesture_state, e);
        if (t.emit)
        begin
            gesture_expect.push_back(t.gesture);
            gesture_state = ST_IDLE;
            timer_armed = 1'b0;
        end
        else
        begin
            gesture_state = t.nxt;
            // entering idle leaves the timer alone
            if (t.nxt != ST_IDLE)
            begin
                if (e == EV_LONG_TO)
                    timer_armed = 1'b0;
                else if (e == EV_SHORT_TO)
                begin
                    countdown = load_count(long_delay_r);
                    pending_long = 1'b1;
                    timer_armed = 1'b1;
                end
                else
                begin
                    countdown = load_count(short_delay_r);
                    pending_long = 1'b0;
                    timer_armed = 1'b1;
                end
            end
        end
    endtask

    task automatic apply_request(logic [REQ_W-1:0] rt, logic [BUTTON_W-1:0] btn);
        if (rt == REQ_PRESS || rt == REQ_RELEASE)
        begin
            if (btn <= 1)
                apply_event(button_event_t'({1'b0, btn[0], rt[0]}));
        end
        else if (rt == REQ_TICK && timer_armed)
        begin
            if (countdown == 0)
            begin
                timer_armed = 1'b0;
                apply_event(pending_long ? EV_LONG_TO : EV_SHORT_TO);
            end
            else if (countdown > COUNT_WIDTH'(tick_step_r))
                countdown = countdown - COUNT_WIDTH'(tick_step_r);
            else
                countdown = '0;
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_taken)
        begin
            if (src_gap > 0)
            begin
                src_gap = src_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                src_gap = $urandom_range(0, 8);
                req_ch.valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                next_word = pending_words.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.req_type <= next_word.req_type;
                req_ch.button <= next_word.button;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result stall driver
    always @(negedge clk)
    begin
        if (!rst_n)
            gest_ch.ready <= 1'b0;
        else if (sink_gap > 0)
        begin
            sink_gap = sink_gap - 1;
            gest_ch.ready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            sink_gap = $urandom_range(0, 8);
            gest_ch.ready <= 1'b0;
        end
        else
            gest_ch.ready <= 1'b1;
    end

    // monitor: predict on accepted requests, check gesture words in order
    always @(posedge clk)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (gest_ch.valid && gest_ch.ready)
            begin
                if (gesture_expect.size() == 0)
                begin
                    $display("%0t: unexpected gesture word, expected none, got %0d",
                             $time, gest_ch.gesture);
                    error_count++;
                end
                else
                begin
                    expected_gesture = gesture_expect.pop_front();
                    if (gest_ch.gesture !== expected_gesture)
                    begin
                        $display("%0t: gesture mismatch, expected %0d, got %0d",
                                 $time, expected_gesture, gest_ch.gesture);
                        error_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                apply_request(req_ch.req_type, req_ch.button);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (gest_ch.valid && gest_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void push_word(logic [REQ_W-1:0] rt, logic [BUTTON_W-1:0] btn);
        req_word_t w;
        w.req_type = rt;
        w.button = btn;
        pending_words.push_back(w);
        items_made++;
    endfunction

    function automatic int ticks_to_fire(logic [DELAY_W-1:0] d);
        if (tick_step_r == 0)
            return (d == 0) ? 1 : 3;
        return int'(d / tick_step_r) + 2;
    endfunction

    function automatic void tick_run(int span);
        repeat ($urandom_range(0, span))
            push_word(REQ_TICK, BUTTON_W'($urandom_range(0, 255)));
    endfunction

    // words that break or garble a gesture
    function automatic void add_noise();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 1) == 0)
                push_word(REQ_W'($urandom_range(0, 3)), BUTTON_W'($urandom_range(0, 1)));
            else
                push_word(REQ_W'($urandom_range(0, 3)), BUTTON_W'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void add_gesture();
        logic [BUTTON_W-1:0] first;
        logic [BUTTON_W-1:0] second;
        int span;
        int settle;
        first = BUTTON_W'($urandom_range(0, 1));
        second = first ^ BUTTON_W'(1);
        span = ticks_to_fire(short_delay_r) * 2;
        if (span > 40)
            span = 40;
        settle = ticks_to_fire(short_delay_r) + ticks_to_fire(long_delay_r) + 2;
        if (settle > 150)
            settle = 150;
        if ($urandom_range(0, 4) == 0)
            add_noise();
        push_word(REQ_PRESS, first);
        tick_run(span);
        case ($urandom_range(0, 3))
            0:
            begin
                push_word(REQ_RELEASE, first);
                tick_run(span);
            end
            1:
            begin
                push_word(REQ_PRESS, second);
                tick_run(span);
                push_word(REQ_RELEASE, first);
                tick_run(span);
                push_word(REQ_RELEASE, second);
            end
            2:
            begin
                // slide from one button to the other
                push_word(REQ_RELEASE, first);
                tick_run(span);
                push_word(REQ_PRESS, second);
                tick_run(span);
                push_word(REQ_RELEASE, second);
            end
            default:
            begin
                push_word(REQ_PRESS, second);
                tick_run(span);
                push_word(REQ_RELEASE, second);
                tick_run(span);
                push_word(REQ_RELEASE, first);
            end
        endcase
        if ($urandom_range(0, 3) != 0)
            repeat (settle)
                push_word(REQ_TICK, BUTTON_W'($urandom_range(0, 255)));
        else
            tick_run(settle);
    endfunction

    task automatic random_phase(int count);
        int target;
        target = items_made + count;
        while (items_made < target)
            add_gesture();
    endtask

    // block is quiet once every word is in and every gesture is out
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || req_ch.valid || gesture_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SHORT_DELAY: short_delay_r = val[DELAY_W-1:0];
            REG_LONG_DELAY:  long_delay_r = val[DELAY_W-1:0];
            REG_TICK_STEP:   tick_step_r = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] short_v, logic [CFG_DATA_W-1:0] long_v,
                              logic [CFG_DATA_W-1:0] step_v);
        wait_idle();
        write_reg(REG_SHORT_DELAY, short_v);
        write_reg(REG_LONG_DELAY, long_v);
        write_reg(REG_TICK_STEP, step_v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_PRESS;
        req_ch.button = '0;
        gest_ch.ready = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // zero delays: every tick on an armed timer fires at once
        set_config(24'd0, 24'd0, 24'h00FFFF);
        push_word(REQ_TICK, 8'd255);
        push_word(REQ_PRESS, 8'd2);
        push_word(REQ_RELEASE, 8'd255);
        push_word(REQ_UNKNOWN, 8'd0);
        push_word(REQ_PRESS, 8'd0);
        push_word(REQ_RELEASE, 8'd0);
        push_word(REQ_TICK, 8'd0);
        push_word(REQ_PRESS, 8'd1);
        push_word(REQ_RELEASE, 8'd1);
        push_word(REQ_TICK, 8'd128);
        push_word(REQ_PRESS, 8'd0);
        push_word(REQ_PRESS, 8'd1);
        push_word(REQ_RELEASE, 8'd0);
        push_word(REQ_PRESS, 8'd0);
        push_word(REQ_TICK, 8'd1);
        push_word(REQ_RELEASE, 8'd0);
        push_word(REQ_PRESS, 8'd1);
        push_word(REQ_TICK, 8'd64);
        push_word(REQ_TICK, 8'd32);
        push_word(REQ_PRESS, 8'd0);
        push_word(REQ_PRESS, 8'd1);
        push_word(REQ_TICK, 8'd170);
        push_word(REQ_TICK, 8'd85);
        random_phase(140);

        set_config(SHORT_DELAY_RESET, LONG_DELAY_RESET, CFG_DATA_W'(TICK_STEP_RESET));
        random_phase(165);
        set_config(24'd3, 24'd5, 24'd1);
        random_phase(165);
        set_config(24'hFFFFFF, 24'hFFFFFF, 24'h00FFFF);
        random_phase(165);
        // upper bits of the step word fall outside the register
        set_config(24'd200, 24'd700, 24'hAB0064);
        random_phase(165);
        // zero step: only an already expired countdown fires
        set_config(24'd0, 24'd2, 24'd0);
        random_phase(165);
        set_config(24'd10, 24'd0, 24'd3);
        random_phase(165);
        set_config(CFG_DATA_W'($urandom_range(0, 60)), CFG_DATA_W'($urandom_range(0, 200)),
                   CFG_DATA_W'($urandom_range(1, 20)));
        random_phase(165);
        set_config(CFG_DATA_W'($urandom_range(0, 60)), CFG_DATA_W'($urandom_range(0, 200)),
                   CFG_DATA_W'($urandom_range(1, 20)));
        random_phase(165);
        idle_enable = 1'b0;
        set_config(24'd5, 24'd9, 24'd2);
        random_phase(165);

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
